>>> sv/bbpd_pkg.sv
// shared constants and types for the blend palette builder
`default_nettype none
package bbpd_pkg;
   localparam int PAL_DEPTH = 1024;
   localparam int PAL_AW    = $clog2(PAL_DEPTH);
   localparam int CNT_W     = PAL_AW + 1;
   localparam int JC_W      = 9;
   localparam int IDX_W     = 8;
   localparam int PI_W      = 10;
   localparam int BC_W      = 11;
   localparam int NEXT_W    = (CNT_W > BC_W) ? CNT_W : BC_W;
   localparam int KEY_W     = 8 * IDX_W;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;
   localparam logic [CSR_AW-1:0] CSR_JOINT_COUNT = 3'd0;

   typedef logic [IDX_W-1:0] byte_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic scan;
      logic finish;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic single;
      logic hit;
      logic scan_end;
   } sts_type;
endpackage
`default_nettype wire

>>> sv/bbpd_ram.sv
// generic single write, single read ram with registered read data
`default_nettype none
module bbpd_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

>>> sv/bbpd_ctrl.sv
// controller: accept, palette scan, result hand-off
`default_nettype none
module bbpd_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output bbpd_pkg::cmd_type     cmd,
   input  wire bbpd_pkg::sts_type sts
);
   import bbpd_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_OUT  = 2'd2;

   logic [1:0] state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      rsp_valid  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.single || sts.hit || sts.scan_end) begin
               cmd.finish = 1'b1;
               state_in   = ST_OUT;
            end
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == ST_SCAN)
      else $error("accepted transfer did not start a scan");
   a_finish_out: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid)
      else $error("finished vertex not presented");
   a_hold_out: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled result dropped");
endmodule
`default_nettype wire

>>> sv/bbpd_dp.sv
// datapath: canonical form, palette scan and append, result registers
`default_nettype none
module bbpd_dp (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire bbpd_pkg::cmd_type          cmd,
   output bbpd_pkg::sts_type               sts,
   input  wire logic [bbpd_pkg::JC_W-1:0]  joint_count,
   input  wire logic                       restart,
   input  wire bbpd_pkg::byte_type         bidx [4],
   input  wire bbpd_pkg::byte_type         bwt [4],
   output logic [bbpd_pkg::PI_W-1:0]       palette_index,
   output logic                            new_entry,
   output logic                            overflow,
   output bbpd_pkg::byte_type              cidx [4],
   output bbpd_pkg::byte_type              cwt [4],
   output logic [bbpd_pkg::BC_W-1:0]       blend_count
);
   import bbpd_pkg::*;

   byte_type          x [4];
   logic [3:0]        nz;
   logic [1:0]        rank [4];
   logic [2:0]        n_nz;
   byte_type          ci_in [4], cw_in [4];
   byte_type          ci_ff [4], cw_ff [4];
   logic              single_ff;
   logic [NEXT_W-1:0] next_ff, first_ff, scan_ff, limit, restart_val;
   logic [PAL_AW-1:0] cmp_ff;
   logic              rd_valid_ff;
   logic [KEY_W-1:0]  key, ram_q;
   logic              issue, full, append;
   logic [PI_W-1:0]   pidx_ff;
   logic              new_ff, ovf_ff;

   // canonical form: rank each nonzero entry among the nonzero ones
   always_comb begin
      n_nz = '0;
      for (int i = 0; i < 4; i++) begin
         nz[i] = (bwt[i] != '0);
         x[i]  = nz[i] ? bidx[i] : '0;
         n_nz  = n_nz + {2'b0, nz[i]};
      end
      for (int i = 0; i < 4; i++) begin
         rank[i] = '0;
         for (int j = 0; j < 4; j++) begin
            if (nz[j] && (j != i) && ((x[j] < x[i]) || ((x[j] == x[i]) && (j < i)))) begin
               rank[i] = rank[i] + 2'd1;
            end
         end
      end
      for (int i = 0; i < 4; i++) begin
         ci_in[i] = '0;
         cw_in[i] = '0;
      end
      for (int i = 0; i < 4; i++) begin
         if (nz[i]) begin
            ci_in[rank[i]] = x[i];
            cw_in[rank[i]] = bwt[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ci_ff     <= ci_in;
         cw_ff     <= cw_in;
         single_ff <= (n_nz <= 3'd1);
      end
   end

   // palette key, index bytes low then weight bytes
   always_comb begin
      key = '0;
      for (int i = 0; i < 4; i++) begin
         key[IDX_W*i +: IDX_W]           = ci_ff[i];
         key[KEY_W/2 + IDX_W*i +: IDX_W] = cw_ff[i];
      end
   end

   assign restart_val = NEXT_W'(joint_count) + NEXT_W'(1);
   assign limit  = (next_ff < NEXT_W'(PAL_DEPTH)) ? next_ff : NEXT_W'(PAL_DEPTH);
   assign full   = (next_ff >= NEXT_W'(PAL_DEPTH));
   assign sts.hit      = cmd.scan && !single_ff && rd_valid_ff && (ram_q == key);
   assign issue        = (scan_ff < limit) && !sts.hit;
   assign sts.scan_end = !rd_valid_ff && !(scan_ff < limit);
   assign sts.single   = single_ff;
   assign append = cmd.finish && !single_ff && !sts.hit && !full;

   // pipelined scan: issue one address, compare the previous read
   always_ff @(posedge clock) begin
      if (reset) begin
         next_ff     <= '0;
         first_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            rd_valid_ff <= 1'b0;
            if (restart) begin
               next_ff  <= restart_val;
               first_ff <= restart_val;
            end
         end else if (cmd.scan) begin
            rd_valid_ff <= issue && !single_ff;
            if (append) begin
               next_ff <= next_ff + NEXT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         scan_ff <= restart ? restart_val : first_ff;
      end else if (cmd.scan && issue) begin
         scan_ff <= scan_ff + NEXT_W'(1);
      end
      cmp_ff <= scan_ff[PAL_AW-1:0];
   end

   bbpd_ram #(.WIDTH(KEY_W), .DEPTH(PAL_DEPTH)) u_ram (
      .clock (clock),
      .we    (append),
      .waddr (next_ff[PAL_AW-1:0]),
      .wdata (key),
      .raddr (scan_ff[PAL_AW-1:0]),
      .rdata (ram_q)
   );

   // result registers
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         new_ff <= append;
         ovf_ff <= !single_ff && !sts.hit && full;
         priority if (single_ff) begin
            pidx_ff <= PI_W'(ci_ff[0]);
         end else if (sts.hit) begin
            pidx_ff <= PI_W'(cmp_ff);
         end else if (full) begin
            pidx_ff <= '0;
         end else begin
            pidx_ff <= PI_W'(next_ff);
         end
      end
   end

   assign palette_index = pidx_ff;
   assign new_entry     = new_ff;
   assign overflow      = ovf_ff;
   assign cidx          = ci_ff;
   assign cwt           = cw_ff;
   assign blend_count   = BC_W'(next_ff);

   a_append_room: assert property (@(posedge clock) disable iff (reset)
      append |-> next_ff < NEXT_W'(PAL_DEPTH))
      else $error("append into a full palette");
   a_append_count: assert property (@(posedge clock) disable iff (reset)
      append |=> next_ff == $past(next_ff) + NEXT_W'(1))
      else $error("palette count not advanced");
   a_scan_window: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan && !single_ff) |-> scan_ff >= first_ff)
      else $error("scan below first appended slot");
endmodule
`default_nettype wire

>>> sv/bone_blend_palette_dedup.sv
// top level: blend palette builder with csr port
// a vertex with at most one weight or an empty scan window goes from the scan state straight
// to the result state, else the scan covers up to n slots, n being the slots from the first
// appended slot to the next free one (linear scan, one palette ram read per cycle), ending on a hit
// one vertex in flight: the next input is taken in the cycle after the result transfer
// reset clears control state and the palette count; ram contents are undefined
`default_nettype none
module bone_blend_palette_dedup (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_restart,
   input  wire logic                          req_final_vertex,
   input  wire logic [7:0]                    req_bone_index_0,
   input  wire logic [7:0]                    req_bone_index_1,
   input  wire logic [7:0]                    req_bone_index_2,
   input  wire logic [7:0]                    req_bone_index_3,
   input  wire logic [7:0]                    req_bone_weight_0,
   input  wire logic [7:0]                    req_bone_weight_1,
   input  wire logic [7:0]                    req_bone_weight_2,
   input  wire logic [7:0]                    req_bone_weight_3,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [9:0]                         rsp_palette_index,
   output logic                               rsp_new_entry,
   output logic                               rsp_overflow,
   output logic [7:0]                         rsp_canon_index_0,
   output logic [7:0]                         rsp_canon_index_1,
   output logic [7:0]                         rsp_canon_index_2,
   output logic [7:0]                         rsp_canon_index_3,
   output logic [7:0]                         rsp_canon_weight_0,
   output logic [7:0]                         rsp_canon_weight_1,
   output logic [7:0]                         rsp_canon_weight_2,
   output logic [7:0]                         rsp_canon_weight_3,
   output logic [10:0]                        rsp_blend_count,
   input  wire logic                          csr_psel,
   input  wire logic                          csr_penable,
   input  wire logic                          csr_pwrite,
   input  wire logic [bbpd_pkg::CSR_AW-1:0]   csr_paddr,
   input  wire logic [bbpd_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [bbpd_pkg::CSR_DW-1:0]        csr_prdata,
   output logic                               csr_pready
);
   import bbpd_pkg::*;

   logic [JC_W-1:0] jc_ff;
   cmd_type         cmd;
   sts_type         sts;
   byte_type        bidx [4], bwt [4], cidx [4], cwt [4];
   logic            unused_final;

   // joint count register
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_JOINT_COUNT) ? CSR_DW'(jc_ff) : '0;
   always_ff @(posedge clock) begin
      if (reset) begin
         jc_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr == CSR_JOINT_COUNT)) begin
         jc_ff <= csr_pwdata[JC_W-1:0];
      end
   end

   // final vertex only marks the stream end; the count is on every transfer
   assign unused_final = req_final_vertex;

   assign bidx[0] = req_bone_index_0;
   assign bidx[1] = req_bone_index_1;
   assign bidx[2] = req_bone_index_2;
   assign bidx[3] = req_bone_index_3;
   assign bwt[0]  = req_bone_weight_0;
   assign bwt[1]  = req_bone_weight_1;
   assign bwt[2]  = req_bone_weight_2;
   assign bwt[3]  = req_bone_weight_3;

   bbpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   bbpd_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .joint_count   (jc_ff),
      .restart       (req_restart),
      .bidx          (bidx),
      .bwt           (bwt),
      .palette_index (rsp_palette_index),
      .new_entry     (rsp_new_entry),
      .overflow      (rsp_overflow),
      .cidx          (cidx),
      .cwt           (cwt),
      .blend_count   (rsp_blend_count)
   );

   assign rsp_canon_index_0  = cidx[0];
   assign rsp_canon_index_1  = cidx[1];
   assign rsp_canon_index_2  = cidx[2];
   assign rsp_canon_index_3  = cidx[3];
   assign rsp_canon_weight_0 = cwt[0];
   assign rsp_canon_weight_1 = cwt[1];
   assign rsp_canon_weight_2 = cwt[2];
   assign rsp_canon_weight_3 = cwt[3];
endmodule
`default_nettype wire

>>> bench/tb_bone_blend_palette_dedup.sv
// self-checking testbench for the blend palette builder
`timescale 1ns / 100ps
`default_nettype none
module tb_bone_blend_palette_dedup;
   import bbpd_pkg::*;

   localparam int WATCHDOG_LIMIT = 6000;
   localparam int HOLD_CYCLES    = 300;

   typedef struct packed {
      logic            restart;
      logic            final_vertex;
      logic [3:0][7:0] idx;
      logic [3:0][7:0] wt;
   } vertex_type;

   typedef struct packed {
      logic [PI_W-1:0] palette_index;
      logic            new_entry;
      logic            overflow;
      logic [3:0][7:0] cidx;
      logic [3:0][7:0] cwt;
      logic [BC_W-1:0] blend_count;
   } outcome_type;

   // palette tracker and store of expected outcomes
   class palette_scoreboard;
      logic [KEY_W-1:0]   blends [PAL_DEPTH];
      int                 next_slot;
      int                 first_slot;
      int                 joints;
      outcome_type        expected [$];
      int                 errors;
      int                 results;
      int                 appended;
      int                 overflows;
      int                 hits;

      function new();
         next_slot  = 0;
         first_slot = 0;
         joints     = 0;
         errors     = 0;
         results    = 0;
         appended   = 0;
         overflows  = 0;
         hits       = 0;
      endfunction

      function void set_joints(int value);
         joints = value;
      endfunction

      function int pending();
         return expected.size();
      endfunction

      // canonicalise a transferred vertex and resolve its palette slot
      function void note_vertex(vertex_type v);
         logic [3:0][7:0]    ci;
         logic [3:0][7:0]    cw;
         logic [7:0]         ti;
         logic [7:0]         tw;
         logic [KEY_W-1:0]   key;
         outcome_type        o;
         int                 n;
         int                 lim;
         int                 result;
         bit                 found;
         ci = '0;
         cw = '0;
         n = 0;
         o = '0;
         if (v.restart) begin
            next_slot  = joints + 1;
            first_slot = next_slot;
         end
         // weighted entries first, in order
         for (int i = 0; i < 4; i++) begin
            if (v.wt[i] != 0) begin
               ci[n] = v.idx[i];
               cw[n] = v.wt[i];
               n++;
            end
         end
         // stable insertion sort on index
         for (int i = 1; i < n; i++) begin
            for (int j = i; j > 0 && ci[j-1] > ci[j]; j--) begin
               ti = ci[j-1]; ci[j-1] = ci[j]; ci[j] = ti;
               tw = cw[j-1]; cw[j-1] = cw[j]; cw[j] = tw;
            end
         end
         result = 0;
         if (cw[1] == 0) begin
            result = ci[0];
         end else begin
            key   = {cw, ci};
            found = 0;
            lim   = (next_slot < PAL_DEPTH) ? next_slot : PAL_DEPTH;
            for (int k = first_slot; k < lim && !found; k++) begin
               if (blends[k] == key) begin
                  result = k;
                  found  = 1;
               end
            end
            if (found) begin
               hits++;
            end else if (next_slot >= PAL_DEPTH) begin
               o.overflow = 1;
               overflows++;
            end else begin
               blends[next_slot] = key;
               result = next_slot;
               next_slot++;
               o.new_entry = 1;
               appended++;
            end
         end
         o.palette_index = result[PI_W-1:0];
         o.cidx          = ci;
         o.cwt           = cw;
         o.blend_count   = next_slot[BC_W-1:0];
         expected.push_back(o);
      endfunction

      function void compare(string name, int exp_v, int act_v);
         if (exp_v != act_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            errors++;
         end
      endfunction

      // compare a result transfer with the oldest expectation
      function void check_result(outcome_type a);
         outcome_type e;
         results++;
         if (expected.size() == 0) begin
            $error("result transfer with no expectation waiting");
            errors++;
            return;
         end
         e = expected.pop_front();
         compare("palette_index", e.palette_index, a.palette_index);
         compare("new_entry", e.new_entry, a.new_entry);
         compare("overflow", e.overflow, a.overflow);
         for (int i = 0; i < 4; i++) begin
            compare($sformatf("canon_index_%0d", i), e.cidx[i], a.cidx[i]);
            compare($sformatf("canon_weight_%0d", i), e.cwt[i], a.cwt[i]);
         end
         compare("blend_count", e.blend_count, a.blend_count);
      endfunction
   endclass

   logic              clock = 0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic              req_restart;
   logic              req_final_vertex;
   logic [7:0]        req_bone_index_0, req_bone_index_1, req_bone_index_2, req_bone_index_3;
   logic [7:0]        req_bone_weight_0, req_bone_weight_1, req_bone_weight_2, req_bone_weight_3;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [9:0]        rsp_palette_index;
   logic              rsp_new_entry;
   logic              rsp_overflow;
   logic [7:0]        rsp_canon_index_0, rsp_canon_index_1, rsp_canon_index_2, rsp_canon_index_3;
   logic [7:0]        rsp_canon_weight_0, rsp_canon_weight_1, rsp_canon_weight_2;
   logic [7:0]        rsp_canon_weight_3;
   logic [10:0]       rsp_blend_count;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   palette_scoreboard sb = new();
   bit                no_idle;
   bit                pressure_done;
   int                idle_cycles;
   logic [3:0][7:0]   pool_idx [8];
   logic [3:0][7:0]   pool_wt [8];

   bone_blend_palette_dedup u_dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_restart, .req_final_vertex,
      .req_bone_index_0, .req_bone_index_1, .req_bone_index_2, .req_bone_index_3,
      .req_bone_weight_0, .req_bone_weight_1, .req_bone_weight_2, .req_bone_weight_3,
      .rsp_valid, .rsp_stall, .rsp_palette_index, .rsp_new_entry, .rsp_overflow,
      .rsp_canon_index_0, .rsp_canon_index_1, .rsp_canon_index_2, .rsp_canon_index_3,
      .rsp_canon_weight_0, .rsp_canon_weight_1, .rsp_canon_weight_2, .rsp_canon_weight_3,
      .rsp_blend_count,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata, .csr_prdata,
      .csr_pready
   );

   always #6 clock = ~clock;

   initial begin
      reset            <= 1;
      req_valid        <= 0;
      req_restart      <= 0;
      req_final_vertex <= 0;
      req_bone_index_0 <= 0; req_bone_index_1 <= 0;
      req_bone_index_2 <= 0; req_bone_index_3 <= 0;
      req_bone_weight_0 <= 0; req_bone_weight_1 <= 0;
      req_bone_weight_2 <= 0; req_bone_weight_3 <= 0;
      rsp_stall        <= 0;
      csr_psel         <= 0;
      csr_penable      <= 0;
      csr_pwrite       <= 0;
      csr_paddr        <= 0;
      csr_pwdata       <= 0;
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // result side: random stalls, one long hold-off
   initial begin
      int gap;
      outcome_type a;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = no_idle ? 0 : $urandom_range(0, 6);
         if (!pressure_done && sb.results == 30) begin
            gap = HOLD_CYCLES;
            pressure_done = 1;
         end
         if (gap > 0) begin
            rsp_stall <= 1;
            repeat (gap) @(negedge clock);
            rsp_stall <= 0;
         end
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         a.palette_index = rsp_palette_index;
         a.new_entry     = rsp_new_entry;
         a.overflow      = rsp_overflow;
         a.cidx          = {rsp_canon_index_3, rsp_canon_index_2,
                            rsp_canon_index_1, rsp_canon_index_0};
         a.cwt           = {rsp_canon_weight_3, rsp_canon_weight_2,
                            rsp_canon_weight_1, rsp_canon_weight_0};
         a.blend_count   = rsp_blend_count;
         sb.check_result(a);
         @(negedge clock);
      end
   end

   // one input transfer, entered and left at a falling edge
   task automatic send_vertex(vertex_type v);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1;
      req_restart       <= v.restart;
      req_final_vertex  <= v.final_vertex;
      req_bone_index_0  <= v.idx[0]; req_bone_index_1 <= v.idx[1];
      req_bone_index_2  <= v.idx[2]; req_bone_index_3 <= v.idx[3];
      req_bone_weight_0 <= v.wt[0]; req_bone_weight_1 <= v.wt[1];
      req_bone_weight_2 <= v.wt[2]; req_bone_weight_3 <= v.wt[3];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_vertex(v);
      @(negedge clock);
   endtask

   // lower valid, then wait until every outcome has come back
   task automatic drain();
      req_valid <= 0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // apb write of the joint count, only while idle
   task automatic write_joints(int value);
      csr_psel    <= 1;
      csr_penable <= 0;
      csr_pwrite  <= 1;
      csr_paddr   <= CSR_JOINT_COUNT;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1;
      @(negedge clock);
      csr_psel    <= 0;
      csr_penable <= 0;
      csr_pwrite  <= 0;
      sb.set_joints(value);
      @(negedge clock);
   endtask

   function automatic vertex_type mk(bit r, bit f, logic [3:0][7:0] i, logic [3:0][7:0] w);
      vertex_type v;
      v.restart      = r;
      v.final_vertex = f;
      v.idx          = i;
      v.wt           = w;
      return v;
   endfunction

   function automatic logic [7:0] rand_weight();
      int r;
      r = $urandom_range(0, 7);
      if (r < 3) return 8'd0;
      if (r == 3) return 8'd255;
      return 8'($urandom_range(1, 255));
   endfunction

   function automatic void refresh_pool(int slot);
      for (int i = 0; i < 4; i++) begin
         pool_idx[slot][i] = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7))
                                                         : 8'($urandom);
         pool_wt[slot][i]  = rand_weight();
      end
      pool_wt[slot][0] = 8'($urandom_range(1, 255));
      pool_wt[slot][1] = 8'($urandom_range(1, 255));
   endfunction

   // mostly reshuffled known blends, some fresh, single and empty
   function automatic vertex_type rand_vertex();
      vertex_type v;
      int sel;
      int rot;
      int p;
      sel = $urandom_range(0, 9);
      v.restart      = ($urandom_range(0, 24) == 0);
      v.final_vertex = ($urandom_range(0, 29) == 0);
      v.idx = $urandom;
      v.wt  = '0;
      if (sel < 6) begin
         p   = $urandom_range(0, 7);
         rot = $urandom_range(0, 3);
         for (int i = 0; i < 4; i++) begin
            v.idx[(i + rot) % 4] = pool_wt[p][i] == 0 ? 8'($urandom) : pool_idx[p][i];
            v.wt[(i + rot) % 4]  = pool_wt[p][i];
         end
         if ($urandom_range(0, 15) == 0) refresh_pool(p);
      end else if (sel < 8) begin
         for (int i = 0; i < 4; i++) v.wt[i] = rand_weight();
      end else if (sel == 8) begin
         v.wt[$urandom_range(0, 3)] = rand_weight();
      end
      return v;
   endfunction

   // stimulus
   initial begin
      vertex_type v;
      int jc_set [3];
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      for (int p = 0; p < 8; p++) refresh_pool(p);
      write_joints(5);

      // directed: no restart yet, so appends begin at slot zero
      send_vertex(mk(0, 0, {8'd9, 8'd9, 8'd3, 8'd5}, {8'd0, 8'd0, 8'd20, 8'd10}));
      send_vertex(mk(0, 0, {8'd0, 8'd0, 8'd5, 8'd3}, {8'd0, 8'd0, 8'd10, 8'd20}));
      send_vertex(mk(0, 0, {4{8'd255}}, {4{8'd0}}));
      send_vertex(mk(0, 0, {8'd200, 8'd1, 8'd2, 8'd3}, {8'd255, 8'd0, 8'd0, 8'd0}));
      send_vertex(mk(1, 0, {8'd1, 8'd128, 8'd0, 8'd255}, {4{8'd255}}));
      send_vertex(mk(0, 0, {4{8'd7}}, {8'd4, 8'd3, 8'd2, 8'd1}));
      send_vertex(mk(0, 0, {4{8'd7}}, {8'd1, 8'd2, 8'd3, 8'd4}));
      send_vertex(mk(0, 0, {8'd255, 8'd1, 8'd128, 8'd0}, {4{8'd255}}));
      send_vertex(mk(0, 0, {4{8'd0}}, {4{8'd0}}));
      send_vertex(mk(0, 0, {4{8'd255}}, {4{8'd255}}));
      send_vertex(mk(0, 0, {8'd0, 8'd40, 8'd0, 8'd30}, {8'd0, 8'd1, 8'd0, 8'd1}));
      send_vertex(mk(0, 0, {8'd30, 8'd0, 8'd40, 8'd0}, {8'd1, 8'd0, 8'd1, 8'd0}));
      send_vertex(mk(0, 1, {8'd4, 8'd3, 8'd2, 8'd1}, {8'd1, 8'd1, 8'd1, 8'd1}));
      send_vertex(mk(1, 1, {8'd0, 8'd0, 8'd0, 8'd77}, {8'd0, 8'd0, 8'd0, 8'd9}));
      drain();

      // random phases over several joint counts
      jc_set[0] = 0;
      jc_set[1] = 256;
      jc_set[2] = $urandom_range(1, 255);
      for (int ph = 0; ph < 3; ph++) begin
         write_joints(jc_set[ph]);
         for (int n = 0; n < 145; n++) begin
            no_idle = (n >= 60 && n < 90);
            v = rand_vertex();
            if (n == 0) v.restart = 1;
            send_vertex(v);
         end
         no_idle = 0;
         drain();
      end
      repeat (20) @(negedge clock);

      if (sb.pending() != 0) begin
         $error("%0d expected outcomes never arrived", sb.pending());
         sb.errors++;
      end
      $display("covered %0d vertices: %0d appended, %0d palette hits, %0d overflows",
               sb.results, sb.appended, sb.hits, sb.overflows);
      $display("joint counts 0, 5, 256 and one random value, with restarts and stalls");
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
